>>> rtl/wofs_pkg.sv
// ----------------------------------------------------------------------------
// wofs_pkg: shared types and constants of the window optical flow solver
// Payload structs, controller commands and the multiplier schedule codes.
// ----------------------------------------------------------------------------
`default_nettype none

package wofs_pkg;

    localparam int FLOW_FRAC_BITS_DEF = 8;
    localparam int SUM_W              = 32;
    localparam int FLOW_W             = 24;
    localparam int PROD_W             = 64;
    localparam int MAG_W              = 65;
    localparam int QUO_W              = 23;
    localparam int DIV_STEPS          = QUO_W + 1;
    localparam int MUL_STEPS          = 6;

    // Multiplier schedule: determinant, then both numerators.
    localparam logic [2:0] MUL_AC  = 3'd0;
    localparam logic [2:0] MUL_BB  = 3'd1;
    localparam logic [2:0] MUL_CTX = 3'd2;
    localparam logic [2:0] MUL_BTY = 3'd3;
    localparam logic [2:0] MUL_ATY = 3'd4;
    localparam logic [2:0] MUL_BTX = 3'd5;

    typedef struct packed {
        logic [7:0] prev_left;
        logic [7:0] prev_right;
        logic [7:0] prev_up;
        logic [7:0] prev_down;
        logic [7:0] prev_center;
        logic [7:0] cur_center;
        logic       last_pixel;
    } pixel_t;

    typedef struct packed {
        logic signed [FLOW_W-1:0] flow_x;
        logic signed [FLOW_W-1:0] flow_y;
        logic                     singular;
    } flow_t;

    typedef struct packed {
        logic       acc_en;
        logic       mul_en;
        logic [2:0] mul_sel;
        logic       div_load;
        logic       div_sel_y;
        logic       div_step;
        logic       out_load;
    } wofs_cmd_t;

    typedef struct packed {
        logic det_zero;
    } wofs_status_t;

endpackage

`default_nettype wire

>>> rtl/wofs_stream_if.sv
// ----------------------------------------------------------------------------
// wofs_stream_if: valid/ready channel
// Carries one payload item per handshake, typed by parameter.
// ----------------------------------------------------------------------------
`default_nettype none

interface wofs_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/wofs_datapath.sv
// ----------------------------------------------------------------------------
// wofs_datapath: accumulators, shared multiplier and restoring divider
// Executes the commands of the controller and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wofs_datapath #(
    parameter int FLOW_FRAC_BITS = wofs_pkg::FLOW_FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wofs_pkg::pixel_t        pix,
    input  wofs_pkg::wofs_cmd_t     cmd,
    output wofs_pkg::wofs_status_t  status,
    output wofs_pkg::flow_t         result
);
    import wofs_pkg::*;

    localparam int DW = MAG_W + QUO_W;

    logic signed [9:0]  dx, dy, gx, gy, dt;
    logic signed [19:0] p_xx, p_xy, p_yy, p_tx, p_ty;
    logic signed [SUM_W-1:0] sxx_reg, sxy_reg, syy_reg, stx_reg, sty_reg;
    logic signed [SUM_W-1:0] sxx_next, sxy_next, syy_next, stx_next, sty_next;
    logic signed [SUM_W-1:0] a_reg, b_reg, c_reg, tx_reg, ty_reg;
    logic signed [SUM_W-1:0] opa, opb;
    logic signed [PROD_W-1:0] prod_reg;
    logic [2:0]  sel_d_reg;
    logic        pv_reg;
    logic signed [MAG_W-1:0] det_reg, nx_reg, ny_reg, prod_ext, num;
    logic [MAG_W-1:0] mag_num, mag_det;
    logic [DW-1:0] rem_reg, dsh_reg;
    logic [QUO_W-1:0] q_reg;
    logic        cap_reg, neg_reg, first_reg, ge;
    logic [FLOW_W-1:0] qv, flow_val;
    logic signed [FLOW_W-1:0] flow_x_tmp_reg;
    flow_t       result_reg;

    function automatic logic signed [19:0] ext_mul(input logic signed [9:0] x,
                                                   input logic signed [9:0] y);
        logic signed [19:0] p;
        p = x * y;
        return p;
    endfunction

    always_comb
    begin
        dx = $signed({2'b00, pix.prev_left}) - $signed({2'b00, pix.prev_right});
        dy = $signed({2'b00, pix.prev_up}) - $signed({2'b00, pix.prev_down});
        // Halve with truncation toward zero: add one to negative values first.
        gx = (dx + $signed({9'd0, dx[9]})) >>> 1;
        gy = (dy + $signed({9'd0, dy[9]})) >>> 1;
        dt = $signed({2'b00, pix.prev_center}) - $signed({2'b00, pix.cur_center});
        p_xx = ext_mul(gx, gx);
        p_xy = ext_mul(gx, gy);
        p_yy = ext_mul(gy, gy);
        p_tx = ext_mul(dt, gx);
        p_ty = ext_mul(dt, gy);
        sxx_next = sxx_reg + {{12{p_xx[19]}}, p_xx};
        sxy_next = sxy_reg + {{12{p_xy[19]}}, p_xy};
        syy_next = syy_reg + {{12{p_yy[19]}}, p_yy};
        stx_next = stx_reg + {{12{p_tx[19]}}, p_tx};
        sty_next = sty_reg + {{12{p_ty[19]}}, p_ty};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sxx_reg <= '0;
            sxy_reg <= '0;
            syy_reg <= '0;
            stx_reg <= '0;
            sty_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            if (pix.last_pixel)
            begin
                sxx_reg <= '0;
                sxy_reg <= '0;
                syy_reg <= '0;
                stx_reg <= '0;
                sty_reg <= '0;
            end
            else
            begin
                sxx_reg <= sxx_next;
                sxy_reg <= sxy_next;
                syy_reg <= syy_next;
                stx_reg <= stx_next;
                sty_reg <= sty_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en && pix.last_pixel)
        begin
            a_reg  <= sxx_next;
            b_reg  <= sxy_next;
            c_reg  <= syy_next;
            tx_reg <= stx_next;
            ty_reg <= sty_next;
        end
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AC:  begin opa = a_reg; opb = c_reg;  end
            MUL_BB:  begin opa = b_reg; opb = b_reg;  end
            MUL_CTX: begin opa = c_reg; opb = tx_reg; end
            MUL_BTY: begin opa = b_reg; opb = ty_reg; end
            MUL_ATY: begin opa = a_reg; opb = ty_reg; end
            MUL_BTX: begin opa = b_reg; opb = tx_reg; end
            default: begin opa = '0;    opb = '0;     end
        endcase
        prod_ext = {prod_reg[PROD_W-1], prod_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pv_reg <= 1'b0;
        else
            pv_reg <= cmd.mul_en;
    end

    always_ff @(posedge clk)
    begin
        prod_reg  <= opa * opb;
        sel_d_reg <= cmd.mul_sel;
        if (pv_reg)
        begin
            case (sel_d_reg)
                MUL_AC:  det_reg <= prod_ext;
                MUL_BB:  det_reg <= det_reg - prod_ext;
                MUL_CTX: nx_reg  <= prod_ext;
                MUL_BTY: nx_reg  <= nx_reg - prod_ext;
                MUL_ATY: ny_reg  <= prod_ext;
                MUL_BTX: ny_reg  <= ny_reg - prod_ext;
                default: ;
            endcase
        end
    end

    assign status.det_zero = (det_reg == '0);

    always_comb
    begin
        num     = cmd.div_sel_y ? ny_reg : nx_reg;
        mag_num = num[MAG_W-1] ? MAG_W'(-num) : MAG_W'(num);
        mag_det = det_reg[MAG_W-1] ? MAG_W'(-det_reg) : MAG_W'(det_reg);
        ge      = (rem_reg >= dsh_reg);
        qv      = cap_reg ? {1'b1, {QUO_W{1'b0}}} : {1'b0, q_reg};
        if (neg_reg)
            flow_val = FLOW_W'(-qv);
        else if (cap_reg)
            flow_val = {1'b0, {QUO_W{1'b1}}};
        else
            flow_val = qv;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            if (cmd.div_sel_y)
                flow_x_tmp_reg <= flow_val;
            rem_reg   <= DW'(mag_num) << FLOW_FRAC_BITS;
            dsh_reg   <= DW'(mag_det) << QUO_W;
            neg_reg   <= num[MAG_W-1] ^ det_reg[MAG_W-1];
            q_reg     <= '0;
            cap_reg   <= 1'b0;
            first_reg <= 1'b1;
        end
        else if (cmd.div_step)
        begin
            // The first compare against divisor << 23 only detects overflow.
            if (first_reg)
                cap_reg <= ge;
            else
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg <= {q_reg[QUO_W-2:0], ge};
            end
            dsh_reg   <= dsh_reg >> 1;
            first_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (status.det_zero)
            begin
                result_reg.flow_x   <= '0;
                result_reg.flow_y   <= '0;
                result_reg.singular <= 1'b1;
            end
            else
            begin
                result_reg.flow_x   <= flow_x_tmp_reg;
                result_reg.flow_y   <= flow_val;
                result_reg.singular <= 1'b0;
            end
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/wofs_ctrl.sv
// ----------------------------------------------------------------------------
// wofs_ctrl: solver sequencer
// Accumulate, multiply schedule, two divisions if det != 0, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module wofs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_last,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wofs_pkg::wofs_status_t status,
    output wofs_pkg::wofs_cmd_t    cmd
);
    import wofs_pkg::*;

    localparam logic [2:0] ST_ACC   = 3'd0;
    localparam logic [2:0] ST_MUL   = 3'd1;
    localparam logic [2:0] ST_SETUP = 3'd2;
    localparam logic [2:0] ST_DIVX  = 3'd3;
    localparam logic [2:0] ST_LOADY = 3'd4;
    localparam logic [2:0] ST_DIVY  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == ST_ACC);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        cmd.mul_sel    = cnt_reg[2:0];
        case (state_reg)
            ST_ACC:
            begin
                cmd.acc_en = in_valid;
                if (in_valid && in_last)
                begin
                    state_next = ST_MUL;
                    cnt_next   = '0;
                end
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(MUL_STEPS))
                    state_next = ST_SETUP;
                else
                    cmd.mul_en = 1'b1;
            end
            ST_SETUP:
            begin
                cnt_next = '0;
                if (status.det_zero)
                    state_next = ST_DONE;
                else
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIVX;
                end
            end
            ST_DIVX:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = ST_LOADY;
            end
            ST_LOADY:
            begin
                cmd.div_load  = 1'b1;
                cmd.div_sel_y = 1'b1;
                cnt_next      = '0;
                state_next    = ST_DIVY;
            end
            ST_DIVY:
            begin
                cmd.div_step  = 1'b1;
                cmd.div_sel_y = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                cmd.div_sel_y = 1'b1;
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_ACC;
                end
            end
            default:
                state_next = ST_ACC;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACC;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/window_optical_flow_solver_top.sv
// ----------------------------------------------------------------------------
// window_optical_flow_solver_top: Lucas-Kanade flow for one window
// Accumulates gradient sums per pixel item and solves the 2x2 system.
// ----------------------------------------------------------------------------
// Usage:
// in_ch takes one window pixel item per cycle while the block accumulates;
// each item is folded into five running sums in the cycle it is accepted.
// An item with last_pixel set starts the solve, and in_ch.ready stays low
// until the solve has placed its result in the output register.
// The solve runs six products through one shared 32x32 multiplier,
// then two restoring divisions of 24 steps each, and registers the result;
// when the determinant is zero it skips the divisions and registers
// singular set with both flows zero.
// Throughput: one item per cycle within a window; the next window is
// not accepted until the sequencer has finished the solve.
// out_ch holds its item until taken; new pixels are accepted while it waits,
// and a finished solve waits in place if the previous result is still held.
// Reset clears the sums, the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module window_optical_flow_solver_top #(
    parameter int FLOW_FRAC_BITS = wofs_pkg::FLOW_FRAC_BITS_DEF
) (
    input  wire logic clk,
    input  wire logic rst_n,
    wofs_stream_if.sink   in_ch,
    wofs_stream_if.source out_ch
);
    import wofs_pkg::*;

    wofs_cmd_t    cmd;
    wofs_status_t status;
    pixel_t       pix;
    flow_t        result;

    assign pix = in_ch.data;

    wofs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (pix.last_pixel),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    wofs_datapath #(
        .FLOW_FRAC_BITS (FLOW_FRAC_BITS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .pix    (pix),
        .cmd    (cmd),
        .status (status),
        .result (result)
    );

    assign out_ch.data = result;

endmodule

`default_nettype wire

>>> rtl/wofs_checker.sv
// ----------------------------------------------------------------------------
// wofs_checker: port-level checks of the flow solver
// Watches the channels of the top level and is bound to it.
// ----------------------------------------------------------------------------
`default_nettype none

module wofs_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        in_last,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [23:0] flow_x,
    input wire logic [23:0] flow_y,
    input wire logic        singular
);

    // A result item stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(flow_x) && $stable(flow_y) && $stable(singular))
        else $error("result item changed while stalled");

    // A singular window reports zero flow.
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> flow_x == 24'd0 && flow_y == 24'd0)
        else $error("singular result with nonzero flow");

    // The solver is busy right after the last pixel of a window.
    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("pixel accepted during solve");

endmodule

bind window_optical_flow_solver_top wofs_checker u_wofs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_last   (in_ch.data.last_pixel),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .flow_x    (out_ch.data.flow_x),
    .flow_y    (out_ch.data.flow_y),
    .singular  (out_ch.data.singular)
);

`default_nettype wire
